### rtl/separable_5tap_image_gradient_defines.svh
// Assertion macros used by the checker file.
`ifndef SEPARABLE_5TAP_IMAGE_GRADIENT_DEFINES_SVH
`define SEPARABLE_5TAP_IMAGE_GRADIENT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define SG_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define SG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

### rtl/sg_pkg.sv
// ----------------------------------------------------------------------------
// sg_pkg
// Shared constants, types and helpers of the separable gradient block.
// ----------------------------------------------------------------------------
package sg_pkg;
    localparam int MAX_WIDTH_DEF      = 2048;
    localparam int MAX_HEIGHT_DEF     = 2048;
    localparam int COEF_FRAC_BITS_DEF = 16;
    localparam int PIX_W   = 16;
    localparam int GRAD_W  = 24;
    localparam int POS_W   = 11;
    localparam int CFG_W   = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // Round half up of value*2^fb/1e6, done at elaboration.
    function automatic longint coef(input longint m, input int fb);
        return ((m << fb) + 64'd500000) / 64'd1000000;
    endfunction

    // Control fields that travel with the arithmetic pipeline.
    typedef struct packed {
        logic             interior;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             frame_end;
    } sg_tag_t;
endpackage

### rtl/sg_line_mem.sv
// ----------------------------------------------------------------------------
// sg_line_mem
// Four line stores packed into one word per column, with a clearing sweep.
// ----------------------------------------------------------------------------
module sg_line_mem
    import sg_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [AW-1:0]       rd_addr,
    output logic [4*PIX_W-1:0]  rd_data,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic [4*PIX_W-1:0]  wr_data,
    output logic                clear_busy
);
    logic [4*PIX_W-1:0] mem [MAX_WIDTH];
    logic [AW:0] clr_reg;
    logic        busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg  <= '0;
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            clr_reg <= clr_reg + 1'b1;
            if (clr_reg == (AW+1)'(MAX_WIDTH - 1)) busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            mem[clr_reg[AW-1:0]] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    assign clear_busy = busy_reg;
endmodule

### rtl/sg_filter.sv
// ----------------------------------------------------------------------------
// sg_filter
// Separable smoothing and derivative pipeline over a 5x5 window.
// ----------------------------------------------------------------------------
module sg_filter
    import sg_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    input  logic signed [PIX_W-1:0]  win [5][5],
    input  sg_tag_t                  in_tag,
    output logic                     out_valid,
    output logic signed [GRAD_W-1:0] grad_x,
    output logic signed [GRAD_W-1:0] grad_y,
    output sg_tag_t                  out_tag
);
    localparam int CW = COEF_FRAC_BITS + 1;
    localparam int SW = PIX_W + CW + 2;
    localparam int DW = SW + CW + 3;
    localparam int RSHIFT = 2 * COEF_FRAC_BITS - 8;
    localparam logic signed [CW:0] C0 = (CW+1)'(coef(37659, COEF_FRAC_BITS));
    localparam logic signed [CW:0] C1 = (CW+1)'(coef(249153, COEF_FRAC_BITS));
    localparam logic signed [CW:0] C2 = (CW+1)'(coef(426375, COEF_FRAC_BITS));
    localparam logic signed [CW:0] D0 = (CW+1)'(coef(109604, COEF_FRAC_BITS));
    localparam logic signed [CW:0] D1 = (CW+1)'(coef(276691, COEF_FRAC_BITS));

    logic signed [SW-1:0] sx_reg [5];
    logic signed [SW-1:0] sy_reg [5];
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic v1_reg, v2_reg;
    sg_tag_t t1_reg, t2_reg;

    function automatic logic signed [SW-1:0] smooth(
        input logic signed [PIX_W-1:0] a, b, c, d, e);
        logic signed [SW-1:0] s;
        s = SW'(C0 * (SW'(a) + SW'(e))) + SW'(C1 * (SW'(b) + SW'(d))) + SW'(C2 * SW'(c));
        return s;
    endfunction

    function automatic logic signed [DW-1:0] deriv(input logic signed [SW-1:0] s [5]);
        return DW'(D0 * (DW'(s[0]) - DW'(s[4]))) + DW'(D1 * (DW'(s[1]) - DW'(s[3])));
    endfunction

    function automatic logic signed [GRAD_W-1:0] rsat(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] r;
        r = (v + (DW'(1) <<< (RSHIFT - 1))) >>> RSHIFT;
        if (r > DW'(8388607)) return GRAD_W'(8388607);
        if (r < -DW'(8388608)) return GRAD_W'(-8388608);
        return GRAD_W'(r);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            out_valid <= 1'b0;
        end else begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            out_valid <= v2_reg;
        end
        for (int k = 0; k < 5; k++) begin
            sx_reg[k] <= smooth(win[0][k], win[1][k], win[2][k], win[3][k], win[4][k]);
            sy_reg[k] <= smooth(win[k][0], win[k][1], win[k][2], win[k][3], win[k][4]);
        end
        t1_reg <= in_tag;
        dx_reg <= deriv(sx_reg);
        dy_reg <= deriv(sy_reg);
        t2_reg <= t1_reg;
        // Border centers report zero gradients.
        grad_x  <= t2_reg.interior ? rsat(dx_reg) : '0;
        grad_y  <= t2_reg.interior ? rsat(dy_reg) : '0;
        out_tag <= t2_reg;
    end
endmodule

### rtl/separable_5tap_image_gradient.sv
// ----------------------------------------------------------------------------
// separable_5tap_image_gradient
// Streaming 5x5 separable derivative gradient over a raster image.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ channel in raster order; each accepted pixel at
// (r,c) yields exactly one result on the m_ channel for center (r-2,c-2).
// Border centers carry interior low and zero gradients.
// One pixel is in flight at a time: the line memory read is registered at
// the accept edge, the window and write-back follow in S_READ, then the
// filter registers (v1_reg, v2_reg, out_valid) and the output register, so
// m_valid rises once the pixel has passed them. s_ready returns in the cycle
// after the result transaction, so a new pixel is taken only after the last
// result has gone; the rate is set by the single transaction in flight.
// After reset the line memory is cleared, one column a cycle across all
// MAX_WIDTH columns, while s_ready stays low; configuration writes are taken at any
// time. A stalled receiver simply holds the result and blocks new pixels.
// Image size registers reset to 640 by 480.
// ----------------------------------------------------------------------------
module separable_5tap_image_gradient
    import sg_pkg::*;
#(
    parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT     = MAX_HEIGHT_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [CFG_W-1:0]         cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [PIX_W-1:0]  s_pixel,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [GRAD_W-1:0] m_grad_x,
    output logic signed [GRAD_W-1:0] m_grad_y,
    output logic                     m_interior,
    output logic [POS_W-1:0]         m_center_row,
    output logic [POS_W-1:0]         m_center_col,
    output logic                     m_frame_end
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CNT_W = $clog2(MAX_HEIGHT > MAX_WIDTH ? MAX_HEIGHT : MAX_WIDTH) + 1;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_BUSY} state_t;
    state_t state_reg;

    logic [CFG_W-1:0] width_reg, height_reg;
    logic [CNT_W-1:0] row_reg, col_reg;
    logic signed [PIX_W-1:0] pix_reg;
    logic signed [PIX_W-1:0] win_reg [5][5];
    logic [AW-1:0] addr_reg;
    logic [4*PIX_W-1:0] rd_data, wr_data;
    logic wr_en, clear_busy, f_valid, fv_valid, busy_reg;
    sg_tag_t tag_reg, f_tag;
    logic signed [GRAD_W-1:0] f_gx, f_gy;
    logic [CNT_W-1:0] w_eff, h_eff, ci;
    logic [CNT_W:0] c1, r1;

    always_comb begin
        w_eff = (width_reg == '0) ? CNT_W'(1)
              : (CNT_W'(width_reg) > CNT_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : CNT_W'(width_reg);
        h_eff = (height_reg == '0) ? CNT_W'(1)
              : (CNT_W'(height_reg) > CNT_W'(MAX_HEIGHT)) ? CNT_W'(MAX_HEIGHT)
              : CNT_W'(height_reg);
        ci = (col_reg < CNT_W'(MAX_WIDTH)) ? col_reg : CNT_W'(MAX_WIDTH - 1);
        c1 = {1'b0, col_reg} + 1'b1;
        r1 = {1'b0, row_reg} + 1'b1;
    end

    assign s_ready = (state_reg == S_IDLE) && !clear_busy && !busy_reg;
    assign wr_en   = (state_reg == S_READ);
    // Lines move up by one; the new pixel goes to the newest line.
    assign wr_data = {pix_reg, rd_data[4*PIX_W-1:PIX_W]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            width_reg  <= CFG_W'(640);
            height_reg <= CFG_W'(480);
            row_reg    <= '0;
            col_reg    <= '0;
            busy_reg   <= 1'b0;
            for (int k = 0; k < 5; k++)
                for (int j = 0; j < 5; j++) win_reg[k][j] <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_wr_data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) busy_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        pix_reg  <= s_pixel;
                        addr_reg <= ci[AW-1:0];
                        busy_reg <= 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    for (int k = 0; k < 5; k++)
                        for (int j = 0; j < 4; j++) win_reg[k][j] <= win_reg[k][j+1];
                    for (int k = 0; k < 4; k++)
                        win_reg[k][4] <= rd_data[k*PIX_W +: PIX_W];
                    win_reg[4][4] <= pix_reg;
                    tag_reg.interior  <= (row_reg >= CNT_W'(4)) && (col_reg >= CNT_W'(4));
                    tag_reg.row       <= POS_W'(row_reg - CNT_W'(2));
                    tag_reg.col       <= POS_W'(col_reg - CNT_W'(2));
                    tag_reg.frame_end <= (c1 >= {1'b0, w_eff}) && (r1 >= {1'b0, h_eff});
                    if (c1 >= {1'b0, w_eff}) begin
                        col_reg <= '0;
                        row_reg <= (r1 >= {1'b0, h_eff}) ? '0 : r1[CNT_W-1:0];
                    end else begin
                        col_reg <= c1[CNT_W-1:0];
                    end
                    state_reg <= S_BUSY;
                end
                S_BUSY: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign fv_valid = (state_reg == S_BUSY);

    sg_line_mem #(.MAX_WIDTH(MAX_WIDTH)) u_mem (
        .aclk(aclk), .aresetn(aresetn),
        .rd_addr(ci[AW-1:0]), .rd_data(rd_data),
        .wr_en(wr_en), .wr_addr(addr_reg), .wr_data(wr_data),
        .clear_busy(clear_busy)
    );

    sg_filter #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_filt (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(fv_valid), .win(win_reg), .in_tag(tag_reg),
        .out_valid(f_valid), .grad_x(f_gx), .grad_y(f_gy), .out_tag(f_tag)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (f_valid) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
        if (f_valid) begin
            m_grad_x     <= f_gx;
            m_grad_y     <= f_gy;
            m_interior   <= f_tag.interior;
            m_center_row <= f_tag.row;
            m_center_col <= f_tag.col;
            m_frame_end  <= f_tag.frame_end;
        end
    end
endmodule

### rtl/sg_checker.sv
// ----------------------------------------------------------------------------
// sg_checker
// Port-level assertions for the separable gradient block.
// ----------------------------------------------------------------------------
`include "separable_5tap_image_gradient_defines.svh"
module sg_checker
    import sg_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic signed [GRAD_W-1:0] m_grad_x,
    input logic signed [GRAD_W-1:0] m_grad_y,
    input logic                     m_interior
);
    // A held result stays valid and keeps its x gradient.
    `SG_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_grad_x), "result changed while stalled")
    // Border centers report zero gradients.
    `SG_ASSERT_IMPL(a_border, aclk, aresetn, m_valid && !m_interior, m_grad_x == '0 && m_grad_y == '0, "nonzero border gradient")
    // Only one pixel is in flight: no new pixel while a result waits.
    `SG_ASSERT_IMPL(a_one, aclk, aresetn, m_valid && !m_ready, !s_ready, "input taken while result pending")
    // An accepted pixel closes the input until its result is out.
    `SG_ASSERT_NEXT(a_close, aclk, aresetn, s_valid && s_ready, !s_ready, "input not closed after accept")
endmodule

bind separable_5tap_image_gradient sg_checker u_sg_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready),
    .m_grad_x(m_grad_x), .m_grad_y(m_grad_y), .m_interior(m_interior)
);
